[hdl/md_pkg.sv]
// Shared types and constants for the squared Mahalanobis distance block.
package md_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;
  localparam int WORD_W  = 32;
  localparam int SAMP_W  = 16;
  localparam int DIMS_W  = 4;
  localparam int DIST_W  = 64;

  // Datapath widths: 18-bit difference, sum of up to 8 row products, final sum of 8 terms
  localparam int DIFF_W  = 18;
  localparam int PROD1_W = DIFF_W + WORD_W;
  localparam int Q_W     = PROD1_W + 3;
  localparam int PROD2_W = Q_W + DIFF_W;
  localparam int ACC_W   = PROD2_W + 3;

  // Upper bound on dimensions that the 3-bit index can reach
  localparam int IDX_LIM = 8;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOAD_COV = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_OFF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_cov;    // write inverse covariance entry
    logic wr_off;    // write offset entry
    logic wr_diff;   // store element difference
    logic start;     // clear row sum and accumulator
    logic mul1;      // d[j] * C[j][k]
    logic acc1;      // add into row sum
    logic mul2;      // row sum * d[k]
    logic acc2;      // add into total, clear row sum
    logic load_out;  // register the scaled, clipped result
  } md_cmd_t;

endpackage

[hdl/mahalanobis_distance.sv]
// Squared Mahalanobis distance, top level: controller plus datapath.
// Load requests (command 0 and 1) and sample elements that are not the last dimension are
// taken without a stall. The sample element whose row index is the last dimension in use
// (n = dims_in_use, zero read as one, clipped to min(DIMS_MAX,8)) starts the quadratic form
// d^T C d, and the input is stalled while the form is computed, longer if the previous
// result is still waiting. The stall is set by the single 18x32 multiply-accumulate that
// walks the matrix one entry at a time (registered
// matrix read, multiply, add) plus a 53x18 multiply and add per column. The result is the
// exact sum shifted right by FRAC_BITS (toward minus infinity), clipped to 64 bits, with
// out_saturated set when clipped. It sits in an output register, so new requests are taken
// while it waits. Tables power up undefined and must be written before use. Write
// dims_in_use only while the block is idle.
module mahalanobis_distance import md_pkg::*; #(
  parameter int DIMS_MAX  = 8,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [WORD_W-1:0] in_matrix_word,
  input  logic signed [SAMP_W-1:0] in_sample_value,
  input  logic signed [SAMP_W-1:0] in_mean_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DIST_W-1:0] out_distance,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIMS_W-1:0]        cfg_dims_in_use
);

  localparam int LIM = (DIMS_MAX < IDX_LIM) ? DIMS_MAX : IDX_LIM;
  localparam int IW  = (LIM > 1) ? $clog2(LIM) : 1;

  md_cmd_t       cmd;
  logic [IW-1:0] j_idx, k_idx;

  md_ctrl #(.DIMS_MAX(DIMS_MAX), .IW(IW)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_dims_in_use (cfg_dims_in_use),
    .cmd             (cmd),
    .j_idx           (j_idx),
    .k_idx           (k_idx)
  );

  md_dpath #(.DIMS_MAX(DIMS_MAX), .FRAC_BITS(FRAC_BITS), .IW(IW)) u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .j_idx           (j_idx),
    .k_idx           (k_idx),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_matrix_word  (in_matrix_word),
    .in_sample_value (in_sample_value),
    .in_mean_value   (in_mean_value),
    .out_distance    (out_distance),
    .out_saturated   (out_saturated)
  );

endmodule

[hdl/md_ctrl.sv]
// Controller: handshakes, dimension register, index counters and sequencing FSM.
module md_ctrl import md_pkg::*; #(
  parameter int DIMS_MAX = 8,
  parameter int IW       = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_row_index,
  input  logic [IDX_W-1:0]  in_col_index,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIMS_W-1:0] cfg_dims_in_use,
  output md_cmd_t           cmd,
  output logic [IW-1:0]     j_idx,
  output logic [IW-1:0]     k_idx
);

  localparam int LIM = (DIMS_MAX < IDX_LIM) ? DIMS_MAX : IDX_LIM;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_ACC1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_ACC2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [IW-1:0]     j_r, j_nxt, k_r, k_nxt;
  logic [DIMS_W-1:0] dims_r, dims_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [DIMS_W-1:0] lim_w, n_eff, n_last;
  logic              accept, row_ok, col_ok, last_elem, j_last, k_last, out_free;

  // Effective dimension count: zero acts as one, clip to table size
  assign lim_w  = DIMS_W'(LIM);
  assign n_eff  = (dims_r == '0) ? DIMS_W'(1) : ((dims_r > lim_w) ? lim_w : dims_r);
  assign n_last = n_eff - DIMS_W'(1);

  assign accept    = in_valid && (state_r == S_IDLE);
  assign row_ok    = {1'b0, in_row_index} < lim_w;
  assign col_ok    = {1'b0, in_col_index} < lim_w;
  assign last_elem = {1'b0, in_row_index} == n_last;
  assign j_last    = DIMS_W'(j_r) == n_last;
  assign k_last    = DIMS_W'(k_r) == n_last;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign j_idx     = j_r;
  assign k_idx     = k_r;

  // Sequence loads, element stores and the quadratic form
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    dims_nxt      = dims_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      dims_nxt = cfg_dims_in_use;
    end

    case (state_r)
      S_IDLE: begin
        if (accept && row_ok) begin
          case (in_command)
            CMD_LOAD_COV: cmd.wr_cov = col_ok;
            CMD_LOAD_OFF: cmd.wr_off = 1'b1;
            CMD_SAMPLE: begin
              cmd.wr_diff = 1'b1;
              if (last_elem) begin
                cmd.start = 1'b1;
                j_nxt     = '0;
                k_nxt     = '0;
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: state_nxt = S_MUL1;
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_ACC1;
      end
      S_ACC1: begin
        cmd.acc1 = 1'b1;
        if (j_last) begin
          state_nxt = S_MUL2;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ACC2;
      end
      S_ACC2: begin
        cmd.acc2 = 1'b1;
        j_nxt    = '0;
        if (k_last) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      k_r         <= '0;
      dims_r      <= DIMS_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      dims_r      <= dims_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/md_dpath.sv]
// Datapath: tables, difference store, two multipliers, accumulators and result register.
module md_dpath import md_pkg::*; #(
  parameter int DIMS_MAX  = 8,
  parameter int FRAC_BITS = 24,
  parameter int IW        = 3
) (
  input  logic                     clk,
  input  md_cmd_t                  cmd,
  input  logic [IW-1:0]            j_idx,
  input  logic [IW-1:0]            k_idx,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [WORD_W-1:0] in_matrix_word,
  input  logic signed [SAMP_W-1:0] in_sample_value,
  input  logic signed [SAMP_W-1:0] in_mean_value,
  output logic signed [DIST_W-1:0] out_distance,
  output logic                     out_saturated
);

  localparam int LIM = (DIMS_MAX < IDX_LIM) ? DIMS_MAX : IDX_LIM;
  localparam int AW  = (LIM > 1) ? $clog2(LIM * LIM) : 1;

  logic signed [WORD_W-1:0]  cov_mem [LIM*LIM];
  logic signed [DIFF_W-1:0]  diff_mem [LIM];
  logic signed [SAMP_W-1:0]  off_r [LIM];

  logic signed [WORD_W-1:0]  c_r;
  logic signed [DIFF_W-1:0]  dj_r, dk_r;
  logic signed [PROD1_W-1:0] prod1_r;
  logic signed [Q_W-1:0]     q_r;
  logic signed [PROD2_W-1:0] prod2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic                      sat_r;

  logic [IW-1:0]             row_ix, col_ix;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-DIST_W:0]     upper;
  logic                      clip;
  logic signed [DIST_W-1:0]  dist_nxt;

  assign row_ix  = in_row_index[IW-1:0];
  assign col_ix  = in_col_index[IW-1:0];
  assign wr_addr = AW'(int'(row_ix) * LIM + int'(col_ix));
  assign rd_addr = AW'(int'(j_idx) * LIM + int'(k_idx));

  // Element difference: sample minus offset minus mean
  assign diff = DIFF_W'(in_sample_value) - DIFF_W'(off_r[row_ix]) - DIFF_W'(in_mean_value);

  // Write tables and register reads
  always_ff @(posedge clk) begin
    if (cmd.wr_cov) begin
      cov_mem[wr_addr] <= in_matrix_word;
    end
    if (cmd.wr_off) begin
      off_r[row_ix] <= in_sample_value;
    end
    if (cmd.wr_diff) begin
      diff_mem[row_ix] <= diff;
    end
    c_r  <= cov_mem[rd_addr];
    dj_r <= diff_mem[j_idx];
    dk_r <= diff_mem[k_idx];
  end

  // Row sum q = sum_j d[j]*C[j][k], then total += q*d[k]
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= dj_r * c_r;
    end
    if (cmd.mul2) begin
      prod2_r <= q_r * dk_r;
    end
    if (cmd.start || cmd.acc2) begin
      q_r <= '0;
    end else if (cmd.acc1) begin
      q_r <= q_r + Q_W'(prod1_r);
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (cmd.acc2) begin
      acc_r <= acc_r + ACC_W'(prod2_r);
    end
  end

  // Drop fraction bits, clip to 64 bits
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DIST_W-1];
  assign clip    = !((&upper) || !(|upper));
  always_comb begin
    if (!clip) begin
      dist_nxt = shifted[DIST_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      dist_nxt = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      dist_nxt = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      dist_r <= dist_nxt;
      sat_r  <= clip;
    end
  end

  assign out_distance  = dist_r;
  assign out_saturated = sat_r;

endmodule

[hdl/md_checker.sv]
// Port-level checker for the Mahalanobis distance block, bound to the top level.
module md_checker import md_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_saturated
);

  // A waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance))
    else $error("stalled result changed or dropped");

  // A clipped result is one of the two 64-bit limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_distance == {1'b1, {(DIST_W-1){1'b0}}}) ||
      (out_distance == {1'b0, {(DIST_W-1){1'b1}}}))
    else $error("saturated flag with unclipped distance");

  // A load request does not stall the input
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_LOAD_COV || in_command == CMD_LOAD_OFF)
      |=> !in_stall)
    else $error("stall after a load request");

  // Out of reset: idle, no result
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind mahalanobis_distance md_checker u_md_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_command    (in_command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_distance  (out_distance),
  .out_saturated (out_saturated)
);

[dv/tb.sv]
// Testbench for mahalanobis_distance: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import md_pkg::*;

  localparam int DMAX        = 8;
  localparam int FRAC        = 24;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 55;
  localparam int LOAD_SETTLE = 20;
  localparam int END_SETTLE  = 300;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [WORD_W-1:0] word;
    logic signed [SAMP_W-1:0] samp;
    logic signed [SAMP_W-1:0] mean;
  } request_t;

  typedef struct {
    logic signed [DIST_W-1:0] distance;
    logic                     sat;
  } distance_t;

  typedef struct {
    request_t                 req;
    bit                       typed;
    logic signed [DIST_W-1:0] distance;
  } vector_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = '0;
  logic [IDX_W-1:0]         in_row_index = '0;
  logic [IDX_W-1:0]         in_col_index = '0;
  logic signed [WORD_W-1:0] in_matrix_word = '0;
  logic signed [SAMP_W-1:0] in_sample_value = '0;
  logic signed [SAMP_W-1:0] in_mean_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DIST_W-1:0] out_distance;
  logic                     out_saturated;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [DIMS_W-1:0]        cfg_dims_in_use = '0;

  // Predictor copy of the block's tables and register
  logic signed [WORD_W-1:0] cov_copy [DMAX][DMAX];
  logic signed [SAMP_W-1:0] offset_copy [DMAX];
  logic signed [DIFF_W-1:0] diff_copy [DMAX];
  logic [DIMS_W-1:0]        dims_copy = 4'd8;

  distance_t pending_distances[$];
  vector_t   directed_vectors[$];
  distance_t oldest;
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;
  int        cycle_count = 0;

  mahalanobis_distance #(.DIMS_MAX(DMAX), .FRAC_BITS(FRAC)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_matrix_word  (in_matrix_word),
    .in_sample_value (in_sample_value),
    .in_mean_value   (in_mean_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_distance    (out_distance),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_dims_in_use (cfg_dims_in_use)
  );

  always #5 clk = ~clk;

  // Clip the register to the dimension count the block uses
  function automatic int dims_used(input logic [DIMS_W-1:0] v);
    if (v == 0) return 1;
    if (v > DMAX) return DMAX;
    return int'(v);
  endfunction

  // Update the table copies; on the last element form d^T C d, scale and clip
  function automatic bit predict_distance(input request_t r, output distance_t e);
    logic signed [127:0]      acc;
    logic signed [127:0]      scaled;
    logic signed [DIST_W-1:0] low;
    e.distance = '0;
    e.sat      = 1'b0;
    case (r.cmd)
      CMD_LOAD_COV: begin
        cov_copy[r.row][r.col] = r.word;
        return 1'b0;
      end
      CMD_LOAD_OFF: begin
        offset_copy[r.row] = r.samp;
        return 1'b0;
      end
      CMD_SAMPLE: begin
        diff_copy[r.row] = $signed(r.samp) - offset_copy[r.row] - $signed(r.mean);
      end
      default: return 1'b0;
    endcase
    if (int'(r.row) != dims_used(dims_copy) - 1) return 1'b0;
    acc = '0;
    for (int k = 0; k < dims_used(dims_copy); k++)
      for (int j = 0; j < dims_used(dims_copy); j++)
        acc = acc + diff_copy[j] * cov_copy[j][k] * diff_copy[k];
    scaled = acc >>> FRAC;
    low    = scaled[DIST_W-1:0];
    e.sat  = (scaled != low);
    if (e.sat)
      e.distance = (scaled < 0) ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    else
      e.distance = low;
    return 1'b1;
  endfunction

  function automatic request_t mk(input int c, input int row, input int col,
                                  input int w, input int s, input int m);
    request_t r;
    r.cmd  = CMD_W'(c);
    r.row  = IDX_W'(row);
    r.col  = IDX_W'(col);
    r.word = WORD_W'(w);
    r.samp = SAMP_W'(s);
    r.mean = SAMP_W'(m);
    return r;
  endfunction

  // Bias random values toward the extremes
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMP_W-1:0] pick_half();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic request_t rand_load();
    logic [CMD_W-1:0] c;
    c = $urandom_range(0, 1) ? CMD_LOAD_OFF : CMD_LOAD_COV;
    return mk(c, $urandom_range(0, 7), $urandom_range(0, 7), pick_word(), pick_half(),
              pick_half());
  endfunction

  // Issue one request in bursts with random gaps; predict on acceptance
  task automatic send(input request_t r, input bit typed, input logic signed [DIST_W-1:0] td);
    distance_t e;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_command      <= r.cmd;
    in_row_index    <= r.row;
    in_col_index    <= r.col;
    in_matrix_word  <= r.word;
    in_sample_value <= r.samp;
    in_mean_value   <= r.mean;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_distance(r, e)) begin
      if (typed) begin
        e.distance = td;
        e.sat      = 1'b0;
      end
      pending_distances.push_back(e);
    end
    if (r.cmd != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // Hold off new requests until every result is back and the block is quiet
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] v);
    cfg_valid       <= 1'b1;
    cfg_dims_in_use <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    dims_copy = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One observation in dimension order, with the odd table load in between
  task automatic send_observation(input int n);
    for (int r = 0; r < n; r++) begin
      if ($urandom_range(0, 5) == 0) send(rand_load(), 1'b0, '0);
      send(mk(CMD_SAMPLE, r, $urandom_range(0, 7), pick_word(), pick_half(), pick_half()),
           1'b0, '0);
    end
  endtask

  task automatic add_vec(input request_t r, input bit typed, input logic signed [DIST_W-1:0] d);
    vector_t v;
    v.req      = r;
    v.typed    = typed;
    v.distance = d;
    directed_vectors.push_back(v);
  endtask

  // Receiver stall pattern: free runs, coin tosses, long holds, alternation
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= 1'b1;
      default: out_stall <= stall_left[0];
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_distances.size() == 0) begin
        $error("unexpected result: distance %0d saturated %0b", out_distance, out_saturated);
        mismatches++;
      end else begin
        oldest = pending_distances.pop_front();
        if (out_distance !== oldest.distance) begin
          $error("distance: expected %0d, actual %0d", oldest.distance, out_distance);
          mismatches++;
        end
        if (out_saturated !== oldest.sat) begin
          $error("saturated: expected %0b, actual %0b", oldest.sat, out_saturated);
          mismatches++;
        end
      end
    end
  end

  // End the run at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int plan [9] = '{8, 15, 0, 1, -1, -1, 4, -1, 8};
    int dims;
    int n;
    int phase_start;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, one dimension: unit scale, signs, rounding, extremes, ignored requests
    write_dims(4'd1);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'h0100_0000, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_LOAD_OFF, 0, 0, 0, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 3, 0), 1'b1, 64'sd9);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, -3, 0), 1'b1, 64'sd9);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 0, 5), 1'b1, 64'sd25);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'hFF00_0000, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 4, 0), 1'b1, -64'sd16);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'h0000_0001, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 1, 0), 1'b1, 64'sd0);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'hFFFF_FFFF, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 1, 0), 1'b1, -64'sd1);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'h7FFF_FFFF, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_LOAD_OFF, 0, 0, 0, 16'h8000, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 16'h7FFF, 16'h8000), 1'b0, '0);
    add_vec(mk(CMD_LOAD_COV, 0, 0, 32'h8000_0000, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 16'h8000, 16'h7FFF), 1'b0, '0);
    add_vec(mk(CMD_LOAD_COV, 7, 7, 32'h1234_5678, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_LOAD_OFF, 7, 0, 0, 16'h7FFF, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 7, 7, 0, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_NONE, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_vec(mk(CMD_LOAD_COV, 3, 5, 32'h0280_0000, 0, 0), 1'b0, '0);
    add_vec(mk(CMD_SAMPLE, 0, 0, 0, 100, -100), 1'b0, '0);
    foreach (directed_vectors[i])
      send(directed_vectors[i].req, directed_vectors[i].typed, directed_vectors[i].distance);

    // Random phases, each under its own dimension count
    foreach (plan[p]) begin
      dims = (plan[p] < 0) ? $urandom_range(1, 8) : plan[p];
      drain(LOAD_SETTLE);
      write_dims(DIMS_W'(dims));
      n = dims_used(DIMS_W'(dims));
      phase_start = items_sent;
      // Fill every table entry before anything reads it
      if (p == 0) begin
        for (int j = 0; j < DMAX; j++)
          for (int k = 0; k < DMAX; k++)
            send(mk(CMD_LOAD_COV, j, k, pick_word(), pick_half(), pick_half()), 1'b0, '0);
        for (int j = 0; j < DMAX; j++)
          send(mk(CMD_LOAD_OFF, j, 0, pick_word(), pick_half(), pick_half()), 1'b0, '0);
        send_observation(DMAX);
      end
      while (items_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: send_observation(n);
          7: send(rand_load(), 1'b0, '0);
          8: send(mk($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom, pick_half(), pick_half()), 1'b0, '0);
          default: send(mk(CMD_SAMPLE, $urandom_range(n - 1, 7), $urandom_range(0, 7),
                           $urandom, pick_half(), pick_half()), 1'b0, '0);
        endcase
      end
    end

    drain(END_SETTLE);
    if (pending_distances.size() != 0) begin
      $error("distance: %0d expected results never arrived", pending_distances.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
